// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL; empty bodies when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent property check, clocked on the rising edge, off during reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never hold at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ----- hw/rtl/clt_pkg.sv -----
// Shared types and constants of the command line tokenizer.
package clt_pkg;

    localparam logic [1:0] KIND_RAW    = 2'd0;
    localparam logic [1:0] KIND_QUOTED = 2'd1;
    localparam logic [1:0] KIND_EQUALS = 2'd2;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_EQUALS    = 8'h3D;

    // One result beat.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       char_valid;
        logic       token_done;
        logic [1:0] token_kind;
        logic       token_error;
    } t_res;

    // Results caused by one input beat (one or two).
    typedef struct packed {
        t_res res0;
        t_res res1;
        logic two;
        logic line_done;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

// ----- hw/rtl/clt_front.sv -----
// Front end: accepts bytes, runs the scanner and builds result entries.
module clt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_in_byte,
    input  logic            i_byte_present,
    input  logic            i_line_end,
    input  logic            i_q_full,
    output logic            o_stall,
    output logic            o_push,
    output clt_pkg::t_entry o_entry
);

    typedef enum logic [2:0] {
        MODE_SKIP,
        MODE_RAW,
        MODE_QUOTED,
        MODE_ESCAPE,
        MODE_OCTAL,
        MODE_DROP
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [7:0]  r_oct_val, n_oct_val;
    logic [1:0]  r_oct_cnt, n_oct_cnt;
    logic        r_qne, n_qne;

    logic           w_accept;
    clt_pkg::t_res  w_res0, w_res1, w_last, w_add;
    logic [1:0]     w_cnt;
    logic           w_need_add;
    logic [8:0]     w_esc;
    logic [7:0]     w_oct_new;
    logic [1:0]     w_oct_cnt_new;
    logic           w_is_ws, w_is_oct;

    function automatic clt_pkg::t_res mk_res(input logic [7:0] b, input logic cv,
                                             input logic done, input logic [1:0] kind,
                                             input logic err);
        clt_pkg::t_res r;
        r.out_byte    = b;
        r.char_valid  = cv;
        r.token_done  = done;
        r.token_kind  = kind;
        r.token_error = err;
        return r;
    endfunction

    // {hit, decoded byte}
    function automatic logic [8:0] esc_map(input logic [7:0] c);
        logic [8:0] m;
        case (c)
            8'h6E:   m = {1'b1, 8'h0A};   // n
            8'h74:   m = {1'b1, 8'h09};   // t
            8'h76:   m = {1'b1, 8'h0B};   // v
            8'h62:   m = {1'b1, 8'h08};   // b
            8'h72:   m = {1'b1, 8'h0D};   // r
            8'h66:   m = {1'b1, 8'h0C};   // f
            8'h3F:   m = {1'b1, 8'h3F};   // ?
            8'h5C:   m = {1'b1, 8'h5C};
            8'h27:   m = {1'b1, 8'h27};
            8'h22:   m = {1'b1, 8'h22};
            default: m = 9'd0;
        endcase
        return m;
    endfunction

    assign o_stall  = i_q_full;
    assign w_accept = i_valid & ~i_q_full;

    assign w_is_ws       = (i_in_byte == 8'h20) || (i_in_byte >= 8'h09 && i_in_byte <= 8'h0D);
    assign w_is_oct      = (i_in_byte >= 8'h30) && (i_in_byte <= 8'h37);
    assign w_esc         = esc_map(i_in_byte);
    assign w_oct_new     = {r_oct_val[4:0], i_in_byte[2:0]};
    assign w_oct_cnt_new = r_oct_cnt + 2'd1;

    always_comb begin
        n_mode     = r_mode;
        n_oct_val  = r_oct_val;
        n_oct_cnt  = r_oct_cnt;
        n_qne      = r_qne;
        w_res0     = '0;
        w_res1     = '0;
        w_cnt      = 2'd0;
        w_last     = '0;
        w_add      = '0;
        w_need_add = 1'b0;

        // byte phase
        if (i_byte_present) begin
            case (r_mode)
                MODE_SKIP: begin
                    if (w_is_ws) begin
                        n_mode = MODE_SKIP;
                    end else if (i_in_byte == clt_pkg::CH_QUOTE) begin
                        n_mode = MODE_QUOTED;
                        n_qne  = 1'b0;
                    end else if (i_in_byte == clt_pkg::CH_EQUALS) begin
                        w_res0 = mk_res(clt_pkg::CH_EQUALS, 1'b1, 1'b1,
                                        clt_pkg::KIND_EQUALS, 1'b0);
                        w_cnt  = 2'd1;
                    end else begin
                        w_res0 = mk_res(i_in_byte, 1'b1, 1'b0, clt_pkg::KIND_RAW, 1'b0);
                        w_cnt  = 2'd1;
                        n_mode = MODE_RAW;
                    end
                end
                MODE_RAW: begin
                    if (w_is_ws) begin
                        w_res0 = mk_res(8'd0, 1'b0, 1'b1, clt_pkg::KIND_RAW, 1'b0);
                        w_cnt  = 2'd1;
                        n_mode = MODE_SKIP;
                    end else if (i_in_byte == clt_pkg::CH_EQUALS) begin
                        w_res0 = mk_res(8'd0, 1'b0, 1'b1, clt_pkg::KIND_RAW, 1'b0);
                        w_res1 = mk_res(clt_pkg::CH_EQUALS, 1'b1, 1'b1,
                                        clt_pkg::KIND_EQUALS, 1'b0);
                        w_cnt  = 2'd2;
                        n_mode = MODE_SKIP;
                    end else begin
                        w_res0 = mk_res(i_in_byte, 1'b1, 1'b0, clt_pkg::KIND_RAW, 1'b0);
                        w_cnt  = 2'd1;
                    end
                end
                MODE_QUOTED: begin
                    if (i_in_byte == clt_pkg::CH_QUOTE) begin
                        w_res0 = mk_res(8'd0, 1'b0, 1'b1, clt_pkg::KIND_QUOTED, ~r_qne);
                        w_cnt  = 2'd1;
                        n_mode = r_qne ? MODE_SKIP : MODE_DROP;
                        n_qne  = 1'b0;
                    end else if (i_in_byte == clt_pkg::CH_BACKSLASH) begin
                        n_mode = MODE_ESCAPE;
                    end else begin
                        w_res0 = mk_res(i_in_byte, 1'b1, 1'b0, clt_pkg::KIND_QUOTED, 1'b0);
                        w_cnt  = 2'd1;
                        n_qne  = 1'b1;
                    end
                end
                MODE_ESCAPE: begin
                    if (w_esc[8]) begin
                        w_res0 = mk_res(w_esc[7:0], 1'b1, 1'b0, clt_pkg::KIND_QUOTED, 1'b0);
                        w_cnt  = 2'd1;
                        n_qne  = 1'b1;
                        n_mode = MODE_QUOTED;
                    end else if (w_is_oct) begin
                        n_oct_val = {5'd0, i_in_byte[2:0]};
                        n_oct_cnt = 2'd1;
                        n_mode    = MODE_OCTAL;
                    end else begin
                        w_res0 = mk_res(8'd0, 1'b0, 1'b1, clt_pkg::KIND_QUOTED, 1'b1);
                        w_cnt  = 2'd1;
                        n_mode = MODE_DROP;
                    end
                end
                MODE_OCTAL: begin
                    if (w_is_oct) begin
                        if (w_oct_cnt_new == 2'd3) begin
                            w_res0    = mk_res(w_oct_new, 1'b1, 1'b0,
                                               clt_pkg::KIND_QUOTED, 1'b0);
                            w_cnt     = 2'd1;
                            n_qne     = 1'b1;
                            n_mode    = MODE_QUOTED;
                            n_oct_val = 8'd0;
                            n_oct_cnt = 2'd0;
                        end else begin
                            n_oct_val = w_oct_new;
                            n_oct_cnt = w_oct_cnt_new;
                        end
                    end else begin
                        w_res0 = mk_res(8'd0, 1'b0, 1'b1, clt_pkg::KIND_QUOTED, 1'b1);
                        w_cnt  = 2'd1;
                        n_mode = MODE_DROP;
                    end
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end

        // line end phase: close what is open, then back to reset state
        if (i_line_end) begin
            w_last = (w_cnt == 2'd2) ? w_res1 : w_res0;
            if ((n_mode == MODE_RAW || n_mode == MODE_QUOTED) && w_cnt != 2'd0 &&
                w_last.char_valid && !w_last.token_done) begin
                if (w_cnt == 2'd2) begin
                    w_res1.token_done = 1'b1;
                end else begin
                    w_res0.token_done = 1'b1;
                end
            end else if (n_mode == MODE_RAW) begin
                w_add      = mk_res(8'd0, 1'b0, 1'b1, clt_pkg::KIND_RAW, 1'b0);
                w_need_add = 1'b1;
            end else if (n_mode == MODE_QUOTED) begin
                w_add      = mk_res(8'd0, 1'b0, 1'b1, clt_pkg::KIND_QUOTED, ~n_qne);
                w_need_add = 1'b1;
            end else if (n_mode == MODE_ESCAPE || n_mode == MODE_OCTAL) begin
                w_add      = mk_res(8'd0, 1'b0, 1'b1, clt_pkg::KIND_QUOTED, 1'b1);
                w_need_add = 1'b1;
            end else begin
                w_need_add = (w_cnt == 2'd0);   // bare line-done beat
            end
            if (w_need_add) begin
                if (w_cnt == 2'd0) begin
                    w_res0 = w_add;
                    w_cnt  = 2'd1;
                end else begin
                    w_res1 = w_add;
                    w_cnt  = 2'd2;
                end
            end
            n_mode    = MODE_SKIP;
            n_oct_val = 8'd0;
            n_oct_cnt = 2'd0;
            n_qne     = 1'b0;
        end
    end

    assign o_push              = w_accept && (w_cnt != 2'd0);
    assign o_entry.res0        = w_res0;
    assign o_entry.res1        = w_res1;
    assign o_entry.two         = (w_cnt == 2'd2);
    assign o_entry.line_done   = i_line_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_SKIP;
            r_oct_val <= 8'd0;
            r_oct_cnt <= 2'd0;
            r_qne     <= 1'b0;
        end else if (w_accept) begin
            r_mode    <= n_mode;
            r_oct_val <= n_oct_val;
            r_oct_cnt <= n_oct_cnt;
            r_qne     <= n_qne;
        end
    end

endmodule

// ----- hw/rtl/clt_queue.sv -----
// Small FIFO of result entries between the front and back ends.
module clt_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  clt_pkg::t_entry  i_entry,
    input  logic             i_pop,
    output clt_pkg::t_entry  o_head,
    output clt_pkg::t_q_stat o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    clt_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;
    logic            w_push, w_pop;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_head       = r_mem[r_rd];

    assign w_push = i_push & ~o_stat.full;
    assign w_pop  = i_pop & ~o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- hw/rtl/clt_back.sv -----
// Back end: splits entries into result beats and holds the output register.
module clt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  clt_pkg::t_entry  i_head,
    input  logic             i_q_empty,
    input  logic             i_stall,
    output logic             o_pop,
    output logic             o_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_char_valid,
    output logic             o_token_done,
    output logic [1:0]       o_token_kind,
    output logic             o_token_error,
    output logic             o_line_done,
    output logic             o_last_result
);

    logic          r_valid;
    logic          r_idx;        // which result of the head entry goes next
    clt_pkg::t_res r_res;
    logic          r_line_done, r_last;

    logic          w_load, w_have, w_is_last;
    clt_pkg::t_res w_sel;

    assign w_load    = ~r_valid | ~i_stall;
    assign w_have    = ~i_q_empty;
    assign w_sel     = r_idx ? i_head.res1 : i_head.res0;
    assign w_is_last = r_idx | ~i_head.two;
    assign o_pop     = w_load & w_have & w_is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else if (w_load) begin
            r_valid <= w_have;
            if (w_have) begin
                r_idx <= ~w_is_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && w_have) begin
            r_res       <= w_sel;
            r_line_done <= w_is_last & i_head.line_done;
            r_last      <= w_is_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_byte    = r_res.out_byte;
    assign o_char_valid  = r_res.char_valid;
    assign o_token_done  = r_res.token_done;
    assign o_token_kind  = r_res.token_kind;
    assign o_token_error = r_res.token_error & r_res.token_done;
    assign o_line_done   = r_line_done;
    assign o_last_result = r_last;

endmodule

// ----- hw/rtl/command_line_tokenizer.sv -----
// Top level of the command line tokenizer: scanner, entry queue, output stage.
//
//  channel | dir | handshake          | fields
//  --------+-----+--------------------+-----------------------------------------
//  input   | in  | i_valid / o_stall  | i_in_byte, i_byte_present, i_line_end
//  result  | out | o_valid / i_stall  | o_out_byte, o_char_valid, o_token_done,
//          |     |                    | o_token_kind, o_token_error,
//          |     |                    | o_line_done, o_last_result
//
// One input beat is taken every cycle while o_stall is low; the scanner state updates in the same
// cycle, so there is no dependency stall between bytes.
// A beat's first result is registered in the entry queue and then in the output register.
// The output port moves one result per cycle while i_stall is low; an input
// that causes two results (a raw word cut by '=') sends them one after the other.
// o_stall is high only while the entry queue (QUEUE_DEPTH entries) is full.
// Reset is synchronous and active low.

`include "assert_macros.svh"

module command_line_tokenizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_byte_present,
    input  logic       i_line_end,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_char_valid,
    output logic       o_token_done,
    output logic [1:0] o_token_kind,
    output logic       o_token_error,
    output logic       o_line_done,
    output logic       o_last_result
);

    // front -> queue
    logic             w_push;
    clt_pkg::t_entry  w_entry;
    // queue -> back
    clt_pkg::t_entry  w_head;
    clt_pkg::t_q_stat w_q_stat;
    logic             w_pop;
    logic             w_accept;

    assign w_accept = i_valid & ~o_stall;

    // Front end: classifies each byte against the scan mode and turns it into
    // zero, one or two results. Empty beats (skipped whitespace, opening
    // quote, backslash, partial octal run, dropped bytes) never reach the
    // queue.
    clt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_in_byte      (i_in_byte),
        .i_byte_present (i_byte_present),
        .i_line_end     (i_line_end),
        .i_q_full       (w_q_stat.full),
        .o_stall        (o_stall),
        .o_push         (w_push),
        .o_entry        (w_entry)
    );

    // Decouples the scanner from output back-pressure.
    clt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    // Back end: one result beat per cycle into the output register while i_stall
    // is low; the head entry is popped when its last result is loaded.
    clt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_q_empty     (w_q_stat.empty),
        .i_stall       (i_stall),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .o_out_byte    (o_out_byte),
        .o_char_valid  (o_char_valid),
        .o_token_done  (o_token_done),
        .o_token_kind  (o_token_kind),
        .o_token_error (o_token_error),
        .o_line_done   (o_line_done),
        .o_last_result (o_last_result)
    );

    // A line end always produces at least one result entry.
    `ASSERT_PROP(a_line_end_pushes, i_clk, i_rst_n, (w_accept && i_line_end) |-> w_push, "line end produced no result")
    // A beat with no byte and no line end reports nothing.
    `ASSERT_NEVER(a_empty_beat_push, i_clk, i_rst_n, w_accept && !i_byte_present && !i_line_end && w_push, "empty beat produced a result")
    // line_done only ever rides on the last result of an input.
    `ASSERT_NEVER(a_line_done_last, i_clk, i_rst_n, o_valid && o_line_done && !o_last_result, "line_done on a non-final result")
    // The queue never pops while empty.
    `ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, w_pop && w_q_stat.empty, "pop from empty queue")

endmodule
